[design/avr_pkg.sv]
// avr_pkg: shared constants, types and the cordic arctangent table
// for the axis vector rotation core; no dependencies
package avr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_DEPTH    = 32;
  localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_DEPTH) ? CORDIC_STAGES : ATAN_DEPTH;
  localparam int SHIFT_W       = $clog2(ATAN_DEPTH);
  localparam int Z_W           = 34;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic signed [31:0] GAIN_Q30   = 32'sd652032874;
  localparam logic signed [16:0] HALF_RIGHT = 17'sd11520;
  localparam logic signed [16:0] HALF_TURN  = 17'sd23040;

  // binary angle = round(mag * 2^32 / 46080) = 93206*mag + (34*mag + 22) / 45
  localparam logic [16:0] ANG_BASE_MUL = 17'd93206;
  localparam logic [5:0]  ANG_REM_MUL  = 6'd34;
  localparam logic [4:0]  ANG_REM_OFS  = 5'd22;
  localparam logic [19:0] ANG_RECIP    = 20'd745655;
  localparam int          ANG_RECIP_SH = 25;
  localparam int          MAG_W        = 14;
  localparam int          REM_W        = 19;
  localparam int          BASE_W       = 31;

  localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } vec_t;

  typedef struct packed {
    logic signed [31:0]    x;
    logic signed [31:0]    y;
    logic signed [Z_W-1:0] z;
  } cord_t;

  typedef struct packed {
    logic signed [34:0] rx;
    logic signed [34:0] ry;
    logic signed [34:0] rz;
  } rot_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               saturated;
  } res_t;

endpackage

[design/avr_if.sv]
// avr_in_if and avr_out_if: valid/ready request channels of the
// axis vector rotation core; no dependencies
interface avr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis;
  logic signed [15:0] angle_deg;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;

  modport source (output valid, axis, angle_deg, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, axis, angle_deg, vec_x, vec_y, vec_z, output ready);
endinterface

interface avr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic               saturated;

  modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

[design/avr_angle.sv]
// avr_angle: folds the half angle and converts it to a binary angle
// in two stages; depends on avr_pkg
module avr_angle import avr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [1:0]         axis_i,
  input  logic signed [15:0] angle_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic               valid_o,
  output vec_t               vec_o,
  output cord_t              cord_o
);

  logic signed [16:0] h, hf, habs;
  logic [MAG_W-1:0]   mag;
  logic [BASE_W-1:0]  base_d, base_q;
  logic [REM_W-1:0]   rem_d, rem_q;
  logic               neg_q;
  logic               v0_q, v1_q;
  vec_t               vec0_q, vec1_q;
  cord_t              cord_d, cord_q;

  logic [REM_W+19:0]  prod;
  logic [MAG_W-1:0]   quo;
  logic [BASE_W-1:0]  zmag;
  logic signed [Z_W-1:0] zpos;

  // fold into [-90, 90] degrees
  always_comb begin
    h = {angle_i[15], angle_i};
    if (h > HALF_RIGHT) begin
      hf = h - HALF_TURN;
    end else if (h < -HALF_RIGHT) begin
      hf = h + HALF_TURN;
    end else begin
      hf = h;
    end
    habs   = hf[16] ? -hf : hf;
    mag    = habs[MAG_W-1:0];
    base_d = BASE_W'(mag) * BASE_W'(ANG_BASE_MUL);
    rem_d  = REM_W'(mag) * REM_W'(ANG_REM_MUL) + REM_W'(ANG_REM_OFS);
  end

  always_comb begin
    prod     = (REM_W+20)'(rem_q) * (REM_W+20)'(ANG_RECIP);
    quo      = prod[ANG_RECIP_SH +: MAG_W];
    zmag     = base_q + BASE_W'(quo);
    zpos     = $signed(Z_W'(zmag));
    cord_d.x = GAIN_Q30;
    cord_d.y = '0;
    cord_d.z = neg_q ? -zpos : zpos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec0_q <= '{axis: axis_i, vx: vec_x_i, vy: vec_y_i, vz: vec_z_i};
      neg_q  <= hf[16];
      base_q <= base_d;
      rem_q  <= rem_d;
      vec1_q <= vec0_q;
      cord_q <= cord_d;
    end
  end

  assign valid_o = v1_q;
  assign vec_o   = vec1_q;
  assign cord_o  = cord_q;

endmodule

[design/avr_cordic_cell.sv]
// avr_cordic_cell: one rotation-mode cordic step with its own register,
// handing vector and angle state to the next cell; depends on avr_pkg
module avr_cordic_cell import avr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [SHIFT_W-1:0]    shift_i,
  input  logic signed [Z_W-1:0] atan_i,
  input  logic                  valid_i,
  input  vec_t                  vec_i,
  input  cord_t                 cord_i,
  output logic                  valid_o,
  output vec_t                  vec_o,
  output cord_t                 cord_o
);

  logic               valid_q;
  vec_t               vec_q;
  cord_t              cord_d, cord_q;
  logic signed [31:0] xs, ys;
  logic               pos;

  always_comb begin
    xs  = cord_i.x >>> shift_i;
    ys  = cord_i.y >>> shift_i;
    pos = ~cord_i.z[Z_W-1];
    if (pos) begin
      cord_d.x = cord_i.x - ys;
      cord_d.y = cord_i.y + xs;
      cord_d.z = cord_i.z - atan_i;
    end else begin
      cord_d.x = cord_i.x + ys;
      cord_d.y = cord_i.y - xs;
      cord_d.z = cord_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q  <= vec_i;
      cord_q <= cord_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign cord_o  = cord_q;

endmodule

[design/avr_combine.sv]
// avr_combine: forms the quaternion sandwich terms from cosine and sine
// and applies them to the vector in four stages; depends on avr_pkg
module avr_combine import avr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  vec_t  vec_i,
  input  cord_t cord_i,
  output logic  valid_o,
  output rot_t  rot_o
);

  localparam logic signed [64:0] RND = 65'sd536870912;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic [1:0]         ax1_q, ax2_q, ax3_q;
  logic signed [31:0] vk, vp, vq;
  logic signed [31:0] vk1_q, vp1_q, vq1_q, vk2_q, vp2_q, vq2_q, vk3_q, vp3_q, vq3_q;
  logic signed [63:0] xx_d, yy_d, xy_d, xx_q, yy_q, xy_q;
  logic signed [64:0] a_s, b_s, d_s;
  logic signed [31:0] ca_q, cb_q, cd_q;
  logic signed [63:0] pk_q, pa_q, pb_q, pc_q, pd_q;
  logic signed [64:0] sk, sp, sq;
  logic signed [34:0] rk, rp, rq;
  rot_t               rot_d, rot_q;

  // k along the axis, plane turned from p toward q
  always_comb begin
    case (vec_i.axis)
      AXIS_Y: begin
        vk = vec_i.vy; vp = vec_i.vz; vq = vec_i.vx;
      end
      AXIS_Z: begin
        vk = vec_i.vz; vp = vec_i.vx; vq = vec_i.vy;
      end
      default: begin
        vk = vec_i.vx; vp = vec_i.vy; vq = vec_i.vz;
      end
    endcase
    xx_d = $signed(cord_i.x) * $signed(cord_i.x);
    yy_d = $signed(cord_i.y) * $signed(cord_i.y);
    xy_d = $signed(cord_i.x) * $signed(cord_i.y);
  end

  always_comb begin
    a_s = xx_q - yy_q + RND;
    b_s = (xy_q <<< 1) + RND;
    d_s = xx_q + yy_q + RND;
  end

  always_comb begin
    sk = pk_q + RND;
    sp = pa_q - pb_q + RND;
    sq = pc_q + pd_q + RND;
    rk = 35'(sk >>> 30);
    rp = 35'(sp >>> 30);
    rq = 35'(sq >>> 30);
    case (ax3_q)
      AXIS_X: begin
        rot_d.rx = rk; rot_d.ry = rp; rot_d.rz = rq;
      end
      AXIS_Y: begin
        rot_d.rx = rq; rot_d.ry = rk; rot_d.rz = rp;
      end
      AXIS_Z: begin
        rot_d.rx = rp; rot_d.ry = rq; rot_d.rz = rk;
      end
      default: begin
        rot_d.rx = 35'(vk3_q); rot_d.ry = 35'(vp3_q); rot_d.rz = 35'(vq3_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q <= vec_i.axis;
      vk1_q <= vk;
      vp1_q <= vp;
      vq1_q <= vq;
      xx_q  <= xx_d;
      yy_q  <= yy_d;
      xy_q  <= xy_d;
      ax2_q <= ax1_q;
      vk2_q <= vk1_q;
      vp2_q <= vp1_q;
      vq2_q <= vq1_q;
      ca_q  <= 32'(a_s >>> 30);
      cb_q  <= 32'(b_s >>> 30);
      cd_q  <= 32'(d_s >>> 30);
      ax3_q <= ax2_q;
      vk3_q <= vk2_q;
      vp3_q <= vp2_q;
      vq3_q <= vq2_q;
      pk_q  <= cd_q * vk2_q;
      pa_q  <= ca_q * vp2_q;
      pb_q  <= cb_q * vq2_q;
      pc_q  <= cb_q * vp2_q;
      pd_q  <= ca_q * vq2_q;
      rot_q <= rot_d;
    end
  end

  assign valid_o = v4_q;
  assign rot_o   = rot_q;

endmodule

[design/axis_vector_rotation_core.sv]
// axis_vector_rotation_core: rotates a Q16.16 vector about a principal axis
// a request passes the angle stages, the cordic cell row, the combine stages and the output buffer
// throughput: one request per cycle while the output buffer is not full, set by the unrolled cordic cell row
// a two-entry output buffer keeps input ready while a result waits
// reset clears the valid flags of every stage and of the output buffer
// depends on avr_pkg, avr_if, avr_angle, avr_cordic_cell, avr_combine
module axis_vector_rotation_core import avr_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  avr_in_if.sink in_i,
  avr_out_if.source out_o
);

  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

  logic  en, push, pop;
  logic  row_v    [NUM_STAGES+1];
  vec_t  row_vec  [NUM_STAGES+1];
  cord_t row_cord [NUM_STAGES+1];
  logic  rot_v;
  rot_t  rot;
  res_t  res;
  logic  out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  res_t  out_q, skid_q;

  function automatic logic [32:0] clamp32(input logic signed [34:0] v);
    logic [32:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, SAT_MAX[31:0]};
    end else if (v < SAT_MIN) begin
      r = {1'b1, SAT_MIN[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  assign en       = ~skid_valid_q;
  assign in_i.ready = en;

  avr_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .axis_i  (in_i.axis),
    .angle_i (in_i.angle_deg),
    .vec_x_i (in_i.vec_x),
    .vec_y_i (in_i.vec_y),
    .vec_z_i (in_i.vec_z),
    .valid_o (row_v[0]),
    .vec_o   (row_vec[0]),
    .cord_o  (row_cord[0])
  );

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    avr_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (SHIFT_W'(g)),
      .atan_i  (ATAN_TAB[g]),
      .valid_i (row_v[g]),
      .vec_i   (row_vec[g]),
      .cord_i  (row_cord[g]),
      .valid_o (row_v[g+1]),
      .vec_o   (row_vec[g+1]),
      .cord_o  (row_cord[g+1])
    );
  end

  avr_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (row_v[NUM_STAGES]),
    .vec_i   (row_vec[NUM_STAGES]),
    .cord_i  (row_cord[NUM_STAGES]),
    .valid_o (rot_v),
    .rot_o   (rot)
  );

  // saturate to 32 bits
  always_comb begin
    logic [32:0] cx, cy, cz;
    cx = clamp32(rot.rx);
    cy = clamp32(rot.ry);
    cz = clamp32(rot.rz);
    res.rot_x     = $signed(cx[31:0]);
    res.rot_y     = $signed(cy[31:0]);
    res.rot_z     = $signed(cz[31:0]);
    res.saturated = cx[32] | cy[32] | cz[32];
  end

  assign push = en & rot_v;
  assign pop  = out_valid_q & out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (push && (pop || !out_valid_q)) begin
      out_q <= res;
    end
    if (push && out_valid_q && !pop) begin
      skid_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.rot_x     = out_q.rot_x;
  assign out_o.rot_y     = out_q.rot_y;
  assign out_o.rot_z     = out_q.rot_z;
  assign out_o.saturated = out_q.saturated;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push)
    else $error("pipeline advanced while output buffer full");

  a_skid_promoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_o.ready) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry not moved to output");

  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready && push) |=> skid_valid_q)
    else $error("result dropped while output stalled");

endmodule
